>>> hw/rtl/hpi_pkg.sv
// Shared types, constants and the saturation helper for the Hermite table interpolator.
// Used by every module of the block; depends on nothing.
package hpi_pkg;

    localparam int WORD_W          = 32;
    localparam int FRAC_W          = 24;
    localparam int IDX_W           = 8;
    localparam int CNT_W           = 9;
    localparam int CFG_IDX_W       = 2;
    localparam int TABLE_DEPTH_DEF = 256;

    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUAD_THR    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CUBIC_THR   = 2'd2;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic [1:0] ORD_LOW_LIN = 2'd0;
    localparam logic [1:0] ORD_LOG_LIN = 2'd1;
    localparam logic [1:0] ORD_QUAD    = 2'd2;
    localparam logic [1:0] ORD_CUBIC   = 2'd3;

    localparam logic [CNT_W-1:0] ENTRY_COUNT_RST = 9'd256;

    typedef logic signed [WORD_W-1:0] t_word;

    localparam t_word Q_ONE    = 32'sh0100_0000;
    localparam t_word WORD_MAX = 32'sh7FFF_FFFF;
    localparam t_word WORD_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic             action;
        logic [IDX_W-1:0] knot_index;
        t_word            knot_abscissa;
        t_word            knot_log_abscissa;
        t_word            knot_value;
        t_word            knot_slope;
        t_word            query_h;
        t_word            query_log_h;
    } t_in;

    typedef struct packed {
        t_word      value_out;
        t_word      slope_out;
        logic [1:0] order_used;
        logic       out_of_range;
        logic       saturated;
    } t_out;

    typedef struct packed {
        logic [CNT_W-1:0] entry_count;
        t_word            quad_threshold;
        t_word            cubic_threshold;
    } t_cfg;

    typedef struct packed {
        logic valid;
        t_in  item;
    } t_qhead;

    typedef struct packed {
        logic  clip;
        t_word value;
    } t_sat;

    // Clamp a wide signed value to the word range and report clipping.
    function automatic t_sat sat_word(input logic signed [63:0] v);
        t_sat r;
        if (v > 64'sd2147483647) begin
            r = '{clip: 1'b1, value: WORD_MAX};
        end else if (v < -64'sd2147483648) begin
            r = '{clip: 1'b1, value: WORD_MIN};
        end else begin
            r = '{clip: 1'b0, value: v[WORD_W-1:0]};
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/hpi_front.sv
// Front end: accepts input beats, drops loads aimed past the table, queues the rest.
// Depends on hpi_pkg.
module hpi_front #(
    parameter int TABLE_DEPTH = hpi_pkg::TABLE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  hpi_pkg::t_in   i_in_data,
    output logic           o_in_stall,
    input  logic           i_pop,
    output hpi_pkg::t_qhead o_head
);
    import hpi_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int IW = (AW + 1 > IDX_W) ? AW + 1 : IDX_W;

    t_in        r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    logic [IW-1:0] idx_ext;
    logic          keep;
    logic          accept;
    logic          push;
    logic          pop;

    assign idx_ext    = IW'(i_in_data.knot_index);
    assign keep       = (i_in_data.action == ACT_QUERY) || (idx_ext < IW'(TABLE_DEPTH));
    assign o_in_stall = (r_cnt == 2'd2);
    assign accept     = i_in_valid && !o_in_stall;
    assign push       = accept && keep;
    assign pop        = i_pop && (r_cnt != 2'd0);

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

>>> hw/rtl/hpi_div.sv
// Sequential signed Q8.24 divider, one quotient bit per cycle, truncating and saturating.
// Depends on hpi_pkg.
module hpi_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  hpi_pkg::t_word i_num,
    input  hpi_pkg::t_word i_den,
    output logic           o_done,
    output hpi_pkg::t_sat  o_res
);
    import hpi_pkg::*;

    localparam int DW = WORD_W + FRAC_W;
    localparam int CW = $clog2(DW);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic              r_neg;
    logic [WORD_W-1:0] r_rem;
    logic [DW-1:0]     r_dvd;
    logic [WORD_W-1:0] r_dvs;

    logic [WORD_W-1:0] mag_n;
    logic [WORD_W-1:0] mag_d;
    logic [WORD_W:0]   rem_sh;
    logic [WORD_W:0]   rem_sub;
    logic              ge;
    logic              over_pos;
    logic              over_neg;

    assign mag_n   = i_num[WORD_W-1] ? (~i_num + 1'b1) : i_num;
    assign mag_d   = i_den[WORD_W-1] ? (~i_den + 1'b1) : i_den;
    assign rem_sh  = {r_rem, r_dvd[DW-1]};
    assign ge      = rem_sh >= {1'b0, r_dvs};
    assign rem_sub = rem_sh - {1'b0, r_dvs};

    // After the last step r_dvd holds the quotient magnitude.
    assign over_pos = |r_dvd[DW-1:WORD_W-1];
    assign over_neg = (|r_dvd[DW-1:WORD_W]) || (r_dvd[WORD_W-1] && (|r_dvd[WORD_W-2:0]));

    always_comb begin
        if (r_neg) begin
            o_res = over_neg ? '{clip: 1'b1, value: WORD_MIN}
                             : '{clip: 1'b0, value: t_word'(~r_dvd[WORD_W-1:0] + 1'b1)};
        end else begin
            o_res = over_pos ? '{clip: 1'b1, value: WORD_MAX}
                             : '{clip: 1'b0, value: t_word'(r_dvd[WORD_W-1:0])};
        end
    end

    assign o_done = r_done;

    // The partial remainder stays below the divisor, so it always fits in one word.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= {mag_n, {FRAC_W{1'b0}}};
            r_rem <= '0;
            r_dvs <= mag_d;
            r_neg <= i_num[WORD_W-1] ^ i_den[WORD_W-1];
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[WORD_W-1:0] : rem_sh[WORD_W-1:0];
            r_dvd <= {r_dvd[DW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

endmodule

>>> hw/rtl/hpi_back.sv
// Back end: knot tables, segment search and a microcoded saturating datapath.
// Depends on hpi_pkg and hpi_div.
module hpi_back #(
    parameter int TABLE_DEPTH = hpi_pkg::TABLE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hpi_pkg::t_qhead i_head,
    output logic            o_pop,
    input  hpi_pkg::t_cfg   i_cfg,
    output logic            o_out_valid,
    output hpi_pkg::t_out   o_out_data,
    input  logic            i_out_stall
);
    import hpi_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = AW + 1;
    localparam int CW = (NW > CNT_W) ? NW : CNT_W;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_RD1  = 9'b000000010,
        S_CLS  = 9'b000000100,
        S_SRCH = 9'b000001000,
        S_CMP  = 9'b000010000,
        S_SEG  = 9'b000100000,
        S_EXEC = 9'b001000000,
        S_DIV  = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

    typedef enum logic [3:0] {
        OP_ADD, OP_SUB, OP_MUL, OP_K2, OP_K3, OP_K4, OP_K6, OP_DIV, OP_BR, OP_END
    } t_op;

    typedef enum logic [4:0] {
        SR_X, SR_XI, SR_XI1, SR_Y1, SR_Y2, SR_D1, SR_D2, SR_DX, SR_U, SR_U2, SR_U3,
        SR_T1, SR_T2, SR_T3, SR_VAL, SR_SLP, SR_ONE
    } t_src;

    typedef enum logic [3:0] {
        DS_DX, DS_U, DS_U2, DS_U3, DS_T1, DS_T2, DS_T3, DS_VAL, DS_SLP, DS_NONE
    } t_dst;

    typedef struct packed {
        t_op  op;
        t_src sa;
        t_src sb;
        t_dst dst;
    } t_uop;

    typedef struct packed {
        t_word x, xi, xi1, y1, y2, d1, d2, dx, u, u2, u3, t1, t2, t3, val, slp;
    } t_opnd;

    localparam logic [5:0] PC_CUBIC = 6'd6;
    localparam logic [5:0] PC_QUAD  = 6'd40;
    localparam logic [5:0] PC_LIN   = 6'd51;

    // Program: shared prologue (width, position, powers), then cubic, quad, linear.
    function automatic t_uop ucode(input logic [5:0] pc);
        t_uop u;
        unique case (pc)
            6'd0:  u = '{OP_SUB, SR_XI1, SR_XI,  DS_DX};
            6'd1:  u = '{OP_SUB, SR_X,   SR_XI,  DS_T1};
            6'd2:  u = '{OP_DIV, SR_T1,  SR_DX,  DS_U};
            6'd3:  u = '{OP_MUL, SR_U,   SR_U,   DS_U2};
            6'd4:  u = '{OP_MUL, SR_U2,  SR_U,   DS_U3};
            6'd5:  u = '{OP_BR,  SR_ONE, SR_ONE, DS_NONE};
            // Cubic Hermite value.
            6'd6:  u = '{OP_K2,  SR_U3,  SR_ONE, DS_T1};
            6'd7:  u = '{OP_K3,  SR_U2,  SR_ONE, DS_T2};
            6'd8:  u = '{OP_SUB, SR_T1,  SR_T2,  DS_T3};
            6'd9:  u = '{OP_ADD, SR_T3,  SR_ONE, DS_T3};
            6'd10: u = '{OP_MUL, SR_Y1,  SR_T3,  DS_VAL};
            6'd11: u = '{OP_SUB, SR_T2,  SR_T1,  DS_T3};
            6'd12: u = '{OP_MUL, SR_Y2,  SR_T3,  DS_T3};
            6'd13: u = '{OP_ADD, SR_VAL, SR_T3,  DS_VAL};
            6'd14: u = '{OP_K2,  SR_U2,  SR_ONE, DS_T1};
            6'd15: u = '{OP_SUB, SR_U3,  SR_T1,  DS_T1};
            6'd16: u = '{OP_ADD, SR_T1,  SR_U,   DS_T1};
            6'd17: u = '{OP_MUL, SR_D1,  SR_DX,  DS_T2};
            6'd18: u = '{OP_MUL, SR_T2,  SR_T1,  DS_T2};
            6'd19: u = '{OP_ADD, SR_VAL, SR_T2,  DS_VAL};
            6'd20: u = '{OP_MUL, SR_D2,  SR_DX,  DS_T1};
            6'd21: u = '{OP_SUB, SR_U3,  SR_U2,  DS_T2};
            6'd22: u = '{OP_MUL, SR_T1,  SR_T2,  DS_T1};
            6'd23: u = '{OP_ADD, SR_VAL, SR_T1,  DS_VAL};
            // Cubic Hermite slope.
            6'd24: u = '{OP_SUB, SR_Y1,  SR_Y2,  DS_T1};
            6'd25: u = '{OP_K6,  SR_T1,  SR_ONE, DS_T1};
            6'd26: u = '{OP_SUB, SR_U2,  SR_U,   DS_T2};
            6'd27: u = '{OP_MUL, SR_T1,  SR_T2,  DS_T1};
            6'd28: u = '{OP_DIV, SR_T1,  SR_DX,  DS_SLP};
            6'd29: u = '{OP_K3,  SR_U2,  SR_ONE, DS_T1};
            6'd30: u = '{OP_K4,  SR_U,   SR_ONE, DS_T2};
            6'd31: u = '{OP_SUB, SR_T1,  SR_T2,  DS_T2};
            6'd32: u = '{OP_ADD, SR_T2,  SR_ONE, DS_T2};
            6'd33: u = '{OP_MUL, SR_D1,  SR_T2,  DS_T2};
            6'd34: u = '{OP_ADD, SR_SLP, SR_T2,  DS_SLP};
            6'd35: u = '{OP_K2,  SR_U,   SR_ONE, DS_T2};
            6'd36: u = '{OP_SUB, SR_T1,  SR_T2,  DS_T2};
            6'd37: u = '{OP_MUL, SR_D2,  SR_T2,  DS_T2};
            6'd38: u = '{OP_ADD, SR_SLP, SR_T2,  DS_SLP};
            6'd39: u = '{OP_END, SR_ONE, SR_ONE, DS_NONE};
            // Quadratic.
            6'd40: u = '{OP_MUL, SR_DX,  SR_D1,  DS_T3};
            6'd41: u = '{OP_SUB, SR_Y2,  SR_Y1,  DS_T1};
            6'd42: u = '{OP_SUB, SR_T1,  SR_T3,  DS_T1};
            6'd43: u = '{OP_MUL, SR_U,   SR_T1,  DS_T1};
            6'd44: u = '{OP_ADD, SR_T3,  SR_T1,  DS_T1};
            6'd45: u = '{OP_MUL, SR_U,   SR_T1,  DS_T1};
            6'd46: u = '{OP_ADD, SR_Y1,  SR_T1,  DS_VAL};
            6'd47: u = '{OP_SUB, SR_D2,  SR_D1,  DS_T2};
            6'd48: u = '{OP_MUL, SR_T2,  SR_U,   DS_T2};
            6'd49: u = '{OP_ADD, SR_D1,  SR_T2,  DS_SLP};
            6'd50: u = '{OP_END, SR_ONE, SR_ONE, DS_NONE};
            // Linear, on either abscissa.
            6'd51: u = '{OP_SUB, SR_Y2,  SR_Y1,  DS_T1};
            6'd52: u = '{OP_MUL, SR_U,   SR_T1,  DS_T1};
            6'd53: u = '{OP_ADD, SR_Y1,  SR_T1,  DS_VAL};
            6'd54: u = '{OP_SUB, SR_D2,  SR_D1,  DS_T2};
            6'd55: u = '{OP_MUL, SR_T2,  SR_U,   DS_T2};
            6'd56: u = '{OP_ADD, SR_D1,  SR_T2,  DS_SLP};
            default: u = '{OP_END, SR_ONE, SR_ONE, DS_NONE};
        endcase
        return u;
    endfunction

    function automatic t_word pick(input t_src s, input t_opnd o);
        t_word w;
        unique case (s)
            SR_X:    w = o.x;
            SR_XI:   w = o.xi;
            SR_XI1:  w = o.xi1;
            SR_Y1:   w = o.y1;
            SR_Y2:   w = o.y2;
            SR_D1:   w = o.d1;
            SR_D2:   w = o.d2;
            SR_DX:   w = o.dx;
            SR_U:    w = o.u;
            SR_U2:   w = o.u2;
            SR_U3:   w = o.u3;
            SR_T1:   w = o.t1;
            SR_T2:   w = o.t2;
            SR_T3:   w = o.t3;
            SR_VAL:  w = o.val;
            SR_SLP:  w = o.slp;
            default: w = Q_ONE;
        endcase
        return w;
    endfunction

    // Knot tables and their registered read ports.
    t_word m_abs [TABLE_DEPTH];
    t_word m_log [TABLE_DEPTH];
    t_word m_val [TABLE_DEPTH];
    t_word m_slp [TABLE_DEPTH];
    t_word r_abs_a, r_abs_b, r_log_a, r_log_b, r_val_a, r_val_b, r_slp_a, r_slp_b;

    t_state     r_state;
    t_state     n_state;
    t_word      r_h, r_lh, r_x;
    logic [1:0] r_order;
    logic       r_oor;
    logic       r_clip;
    logic [AW-1:0] r_lo, r_hi, r_mid;
    logic [5:0] r_pc;
    t_word      r_dx, r_u, r_u2, r_u3, r_t1, r_t2, r_t3, r_val, r_slp;
    logic       r_ov;
    t_out       r_out;

    logic [CW-1:0] ec;
    logic [CW-1:0] n_eff;
    logic [AW-1:0] n_last;
    logic [AW-1:0] mid;
    logic [AW:0]   lo_p1;
    logic [AW-1:0] addr_a, addr_b;
    logic [AW-1:0] waddr;
    logic          wr;
    logic          is_low;
    t_word         srch_val;
    t_opnd         opnd;
    t_uop          uop;
    t_word         opa, opb;
    logic signed [63:0] a64, b64, prod, k3;
    t_sat          alu;
    logic          div_start;
    logic          div_done;
    t_sat          div_res;
    logic          wen;
    t_sat          wres;
    logic          out_free;

    assign ec     = CW'(i_cfg.entry_count);
    assign n_eff  = (ec < CW'(3)) ? CW'(3) : ((ec > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : ec);
    assign n_last = AW'(n_eff - CW'(1));
    assign mid    = AW'(({1'b0, r_lo} + {1'b0, r_hi}) >> 1);
    assign lo_p1  = {1'b0, r_lo} + 1'b1;

    assign addr_a = (r_state == S_RD1) ? n_last : ((r_state == S_SRCH) ? mid : r_lo);
    assign addr_b = (r_state == S_RD1) ? AW'(1) : (r_lo + 1'b1);

    assign o_pop = (r_state == S_IDLE) && i_head.valid;
    assign wr    = o_pop && (i_head.item.action == ACT_LOAD);
    assign waddr = AW'(i_head.item.knot_index);

    always_ff @(posedge i_clk) begin
        if (wr) begin
            m_abs[waddr] <= i_head.item.knot_abscissa;
            m_log[waddr] <= i_head.item.knot_log_abscissa;
            m_val[waddr] <= i_head.item.knot_value;
            m_slp[waddr] <= i_head.item.knot_slope;
        end
        r_abs_a <= m_abs[addr_a];
        r_abs_b <= m_abs[addr_b];
        r_log_a <= m_log[addr_a];
        r_log_b <= m_log[addr_b];
        r_val_a <= m_val[addr_a];
        r_val_b <= m_val[addr_b];
        r_slp_a <= m_slp[addr_a];
        r_slp_b <= m_slp[addr_b];
    end

    assign is_low   = (r_order == ORD_LOW_LIN);
    assign srch_val = is_low ? r_abs_a : r_log_a;

    always_comb begin
        opnd = '{x: r_x, xi: srch_val, xi1: (is_low ? r_abs_b : r_log_b),
                 y1: r_val_a, y2: r_val_b, d1: r_slp_a, d2: r_slp_b,
                 dx: r_dx, u: r_u, u2: r_u2, u3: r_u3, t1: r_t1, t2: r_t2, t3: r_t3,
                 val: r_val, slp: r_slp};
        uop  = ucode(r_pc);
        opa  = pick(uop.sa, opnd);
        opb  = pick(uop.sb, opnd);
    end

    // One saturating op per cycle outside divides; products round to nearest, ties up.
    always_comb begin
        a64  = opa;
        b64  = opb;
        prod = a64 * b64 + 64'sd8388608;
        k3   = a64 + (a64 <<< 1);
        unique case (uop.op)
            OP_ADD:  alu = sat_word(a64 + b64);
            OP_SUB:  alu = sat_word(a64 - b64);
            OP_MUL:  alu = sat_word(prod >>> FRAC_W);
            OP_K2:   alu = sat_word(a64 <<< 1);
            OP_K3:   alu = sat_word(k3);
            OP_K4:   alu = sat_word(a64 <<< 2);
            OP_K6:   alu = sat_word(k3 <<< 1);
            default: alu = '{clip: 1'b0, value: '0};
        endcase
    end

    assign div_start = (r_state == S_EXEC) && (uop.op == OP_DIV) && (opb != '0);

    hpi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (opa),
        .i_den   (opb),
        .o_done  (div_done),
        .o_res   (div_res)
    );

    always_comb begin
        wen  = 1'b0;
        wres = alu;
        if (r_state == S_EXEC) begin
            unique case (uop.op)
                OP_BR, OP_END: wen = 1'b0;
                OP_DIV: begin
                    wen  = (opb == '0);
                    wres = '{clip: 1'b0, value: '0};
                end
                default: wen = 1'b1;
            endcase
        end else if ((r_state == S_DIV) && div_done) begin
            wen  = 1'b1;
            wres = div_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wen) begin
            unique case (uop.dst)
                DS_DX:   r_dx  <= wres.value;
                DS_U:    r_u   <= wres.value;
                DS_U2:   r_u2  <= wres.value;
                DS_U3:   r_u3  <= wres.value;
                DS_T1:   r_t1  <= wres.value;
                DS_T2:   r_t2  <= wres.value;
                DS_T3:   r_t3  <= wres.value;
                DS_VAL:  r_val <= wres.value;
                DS_SLP:  r_slp <= wres.value;
                default: r_t3  <= r_t3;
            endcase
        end
    end

    assign out_free = !r_ov || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (o_pop && (i_head.item.action == ACT_QUERY)) begin
                n_state = S_RD1;
            end
            S_RD1:  n_state = S_CLS;
            S_CLS:  n_state = S_SRCH;
            S_SRCH: n_state = ({1'b0, r_hi} > lo_p1) ? S_CMP : S_SEG;
            S_CMP:  n_state = S_SRCH;
            S_SEG:  n_state = S_EXEC;
            S_EXEC: begin
                if (uop.op == OP_END) begin
                    n_state = S_OUT;
                end else if (div_start) begin
                    n_state = S_DIV;
                end
            end
            S_DIV:  if (div_done) begin
                n_state = S_EXEC;
            end
            S_OUT:  if (out_free) begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_h  <= i_head.item.query_h;
                r_lh <= i_head.item.query_log_h;
            end
            S_CLS: begin
                r_oor <= (r_h > r_abs_a);
                r_lo  <= '0;
                r_hi  <= n_last;
                if (r_h <= r_abs_b) begin
                    r_order <= ORD_LOW_LIN;
                    r_x     <= r_h;
                end else begin
                    r_x <= r_lh;
                    if ((r_lh > i_cfg.cubic_threshold) && (r_lh > i_cfg.quad_threshold)) begin
                        r_order <= ORD_CUBIC;
                    end else if (r_lh > i_cfg.quad_threshold) begin
                        r_order <= ORD_QUAD;
                    end else begin
                        r_order <= ORD_LOG_LIN;
                    end
                end
            end
            S_SRCH: r_mid <= mid;
            S_CMP: begin
                if (srch_val > r_x) begin
                    r_hi <= r_mid;
                end else begin
                    r_lo <= r_mid;
                end
            end
            default: r_mid <= r_mid;
        endcase
        if (r_state == S_OUT && out_free) begin
            r_out <= '{value_out: r_val, slope_out: r_slp, order_used: r_order,
                       out_of_range: r_oor, saturated: r_clip};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
            r_clip  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE) begin
                r_clip <= 1'b0;
            end else if (wen) begin
                r_clip <= r_clip | wres.clip;
            end
            if (r_state == S_SEG) begin
                r_pc <= '0;
            end else if (r_state == S_EXEC) begin
                if (uop.op == OP_BR) begin
                    priority case (r_order)
                        ORD_CUBIC: r_pc <= PC_CUBIC;
                        ORD_QUAD:  r_pc <= PC_QUAD;
                        default:   r_pc <= PC_LIN;
                    endcase
                end else if (wen) begin
                    r_pc <= r_pc + 6'd1;
                end
            end else if ((r_state == S_DIV) && div_done) begin
                r_pc <= r_pc + 6'd1;
            end
            if (r_state == S_OUT && out_free) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

endmodule

>>> hw/rtl/piecewise_hermite_table_interp.sv
// Top level of the piecewise Hermite table interpolator: configuration registers and
// the front end, queue and back end. Depends on hpi_pkg, hpi_front and hpi_back.
//
//   Channel   Direction  Handshake              Beat
//   input     in         i_in_valid/o_in_stall  hpi_pkg::t_in (one load or one query)
//   output    out        o_out_valid/i_out_stall hpi_pkg::t_out (one per query)
//   config    in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// A load beat writes one knot when the idle back end pops it from the head of the queue.
// A query leaves the queue, is classified and binary-searched in the table with one
// table read per search step, then runs the datapath program step by step, waiting on
// the sequential divider for each divide, and hands the result to the output register.
// Reset is synchronous and active low and empties the queue and the output register;
// the knot tables are not cleared. The two-beat queue keeps input beats flowing while
// the back end works, and the output register holds a finished result under stall
// while the back end goes on to the next query.
module piecewise_hermite_table_interp #(
    parameter int TABLE_DEPTH = hpi_pkg::TABLE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  hpi_pkg::t_in                     i_in_data,
    output logic                             o_in_stall,
    output logic                             o_out_valid,
    output hpi_pkg::t_out                    o_out_data,
    input  logic                             i_out_stall,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [hpi_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [hpi_pkg::WORD_W-1:0]       i_cfg_data
);
    import hpi_pkg::*;

    t_cfg   r_cfg;
    t_qhead head;
    logic   pop;

    // Configuration writes are always taken; an unknown index is ignored.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{entry_count: ENTRY_COUNT_RST, quad_threshold: '0, cubic_threshold: '0};
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ENTRY_COUNT: r_cfg.entry_count     <= i_cfg_data[CNT_W-1:0];
                CFG_QUAD_THR:    r_cfg.quad_threshold  <= t_word'(i_cfg_data);
                CFG_CUBIC_THR:   r_cfg.cubic_threshold <= t_word'(i_cfg_data);
                default:         r_cfg <= r_cfg;
            endcase
        end
    end

    // The front end accepts beats and drops loads that address past the table.
    hpi_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_pop      (pop),
        .o_head     (head)
    );

    // The back end owns the knot tables and evaluates queries one at a time.
    hpi_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .i_cfg       (r_cfg),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

>>> tb/sv/piecewise_hermite_table_interp_test.sv
// Self-checking testbench for the piecewise Hermite table interpolator.
// Depends on hpi_pkg and the piecewise_hermite_table_interp top level.
module piecewise_hermite_table_interp_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hpi_pkg::*;

    localparam int DEPTH      = 256;
    localparam int DRAIN_WAIT = 600;
    localparam int HOLD_LEN   = 500;
    localparam longint ONE_Q  = 64'sd16777216;

    logic          i_clk;
    logic          i_rst_n;
    logic          in_valid;
    t_in           in_data;
    logic          o_in_stall;
    logic          o_out_valid;
    t_out          o_out_data;
    logic          out_stall;
    logic          cfg_valid;
    logic          o_cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0]    cfg_data;

    piecewise_hermite_table_interp dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (out_stall),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Beats waiting to be offered, and the results the predictor expects in order.
    t_in    pending_beats[$];
    t_out   expected_results[$];
    int     fail_count = 0;
    longint cycle_count = 0;
    logic   hold_req = 1'b0;
    logic   hold_done;
    int     hold_cnt;

    // Predictor copy of the knot tables and the configuration registers.
    longint knot_abs[DEPTH];
    longint knot_log[DEPTH];
    longint knot_val[DEPTH];
    longint knot_slp[DEPTH];
    int     cfg_count = 256;
    longint cfg_quad = 0;
    longint cfg_cubic = 0;
    bit     clip_flag;

    // Shadow of the table as the stimulus generator last wrote it.
    longint gen_abs[DEPTH];
    longint gen_log[DEPTH];
    int     gen_count = 256;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // No idling at all for a long stretch of every period of the cycle counter.
    wire quiet = (cycle_count % 16384) >= 13000;

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // ---------------------------------------------------------------------------------
    // Saturating Q8.24 arithmetic, as the block performs it on 32-bit words.
    // ---------------------------------------------------------------------------------
    function automatic longint sat(longint v);
        if (v > 64'sd2147483647) begin
            clip_flag = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            clip_flag = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint wadd(longint a, longint b);
        return sat(a + b);
    endfunction

    function automatic longint wsub(longint a, longint b);
        return sat(a - b);
    endfunction

    function automatic longint wk(longint a, longint k);
        return sat(a * k);
    endfunction

    // Products round to nearest with ties going up.
    function automatic longint wmul(longint a, longint b);
        longint p;
        longint q;
        p = a * b + ONE_Q / 2;
        if (p >= 0) q = p >>> 24;
        else q = -((-p + ONE_Q - 1) >>> 24);
        return sat(q);
    endfunction

    // Quotients truncate toward zero; a zero divisor gives zero.
    function automatic longint wdiv(longint a, longint b);
        if (b == 0) return 0;
        return sat((a * ONE_Q) / b);
    endfunction

    function automatic longint knot_x(bit on_abs, int idx);
        return on_abs ? knot_abs[idx] : knot_log[idx];
    endfunction

    // Expected result of one query beat against the current table and registers.
    function automatic t_out hermite_predict(t_in b);
        t_out   r;
        int     n, lo, hi, mid, i;
        bit     on_abs;
        longint h, lh, x, dx, u, u2, u3, y1, y2, d1, d2, val, slp, t, m;
        logic [1:0] ord;

        clip_flag = 1'b0;
        n = cfg_count;
        if (n < 3) n = 3;
        if (n > DEPTH) n = DEPTH;
        h  = longint'(b.query_h);
        lh = longint'(b.query_log_h);
        r.out_of_range = (h > knot_abs[n-1]);

        if (h <= knot_abs[1]) begin
            ord = ORD_LOW_LIN;
            on_abs = 1'b1;
            x = h;
        end else begin
            on_abs = 1'b0;
            x = lh;
            if (lh > cfg_cubic && lh > cfg_quad) ord = ORD_CUBIC;
            else if (lh > cfg_quad) ord = ORD_QUAD;
            else ord = ORD_LOG_LIN;
        end

        // Binary search for the bracketing segment; ends clamp to the first or last one.
        lo = 0;
        hi = n - 1;
        while (hi > lo + 1) begin
            mid = (lo + hi) / 2;
            if (knot_x(on_abs, mid) > x) hi = mid;
            else lo = mid;
        end
        i = lo;

        dx = wsub(knot_x(on_abs, i + 1), knot_x(on_abs, i));
        u  = wdiv(wsub(x, knot_x(on_abs, i)), dx);
        y1 = knot_val[i];
        y2 = knot_val[i+1];
        d1 = knot_slp[i];
        d2 = knot_slp[i+1];
        u2 = wmul(u, u);
        u3 = wmul(u2, u);

        if (ord == ORD_CUBIC) begin
            t   = wadd(wsub(wk(u3, 2), wk(u2, 3)), ONE_Q);
            val = wmul(y1, t);
            val = wadd(val, wmul(y2, wsub(wk(u2, 3), wk(u3, 2))));
            t   = wadd(wsub(u3, wk(u2, 2)), u);
            val = wadd(val, wmul(wmul(d1, dx), t));
            val = wadd(val, wmul(wmul(d2, dx), wsub(u3, u2)));
            slp = wdiv(wmul(wk(wsub(y1, y2), 6), wsub(u2, u)), dx);
            t   = wadd(wsub(wk(u2, 3), wk(u, 4)), ONE_Q);
            slp = wadd(slp, wmul(d1, t));
            slp = wadd(slp, wmul(d2, wsub(wk(u2, 3), wk(u, 2))));
        end else if (ord == ORD_QUAD) begin
            m   = wmul(dx, d1);
            t   = wmul(u, wsub(wsub(y2, y1), m));
            val = wadd(y1, wmul(u, wadd(m, t)));
            slp = wadd(d1, wmul(wsub(d2, d1), u));
        end else begin
            val = wadd(y1, wmul(u, wsub(y2, y1)));
            slp = wadd(d1, wmul(wsub(d2, d1), u));
        end

        r.value_out  = val[31:0];
        r.slope_out  = slp[31:0];
        r.order_used = ord;
        r.saturated  = clip_flag;
        return r;
    endfunction

    // Apply one accepted input beat to the predictor.
    task automatic absorb_beat(t_in b);
        if (b.action == ACT_LOAD) begin
            knot_abs[b.knot_index] = longint'(b.knot_abscissa);
            knot_log[b.knot_index] = longint'(b.knot_log_abscissa);
            knot_val[b.knot_index] = longint'(b.knot_value);
            knot_slp[b.knot_index] = longint'(b.knot_slope);
        end else begin
            expected_results.push_back(hermite_predict(b));
        end
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got,
                 want);
        fail_count++;
    endtask

    // ---------------------------------------------------------------------------------
    // Input driver. An offered beat is held until accepted; a new beat is offered only
    // after the previous one went through, so valid changes once per step at most.
    // ---------------------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic holding;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            holding = in_valid;
            if (in_valid && !o_in_stall) begin
                absorb_beat(in_data);
                void'(pending_beats.pop_front());
                holding = 1'b0;
            end
            if (!holding) begin
                if (pending_beats.size() > 0 && (quiet || $urandom_range(99) >= 18)) begin
                    in_valid <= 1'b1;
                    in_data  <= pending_beats[0];
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output stall: random idling, quiet stretches, and one long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt  <= hold_cnt - 1;
            out_stall <= 1'b1;
        end else if (hold_req && !hold_done) begin
            hold_cnt  <= HOLD_LEN;
            hold_done <= 1'b1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= !quiet && ($urandom_range(99) < 18);
        end
    end

    // Result monitor: every accepted result beat is checked against the oldest expectation.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                $display("unexpected result beat at cycle %0d", cycle_count);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_out_data.value_out !== want.value_out)
                    report_mismatch("value_out", o_out_data.value_out, want.value_out);
                if (o_out_data.slope_out !== want.slope_out)
                    report_mismatch("slope_out", o_out_data.slope_out, want.slope_out);
                if (o_out_data.order_used !== want.order_used)
                    report_mismatch("order_used", o_out_data.order_used, want.order_used);
                if (o_out_data.out_of_range !== want.out_of_range)
                    report_mismatch("out_of_range", o_out_data.out_of_range,
                                    want.out_of_range);
                if (o_out_data.saturated !== want.saturated)
                    report_mismatch("saturated", o_out_data.saturated, want.saturated);
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Stimulus helpers.
    // ---------------------------------------------------------------------------------
    function automatic t_word any_word();
        case ($urandom_range(7))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return 32'sd0;
            3, 4: return t_word'($urandom());
            default: return t_word'(int'($urandom_range(1 << 26)) - (1 << 25));
        endcase
    endfunction

    function automatic t_in load_beat(int idx, longint xa, longint xl, t_word v, t_word s);
        t_in b;
        b.action            = ACT_LOAD;
        b.knot_index        = idx[IDX_W-1:0];
        b.knot_abscissa     = xa[31:0];
        b.knot_log_abscissa = xl[31:0];
        b.knot_value        = v;
        b.knot_slope        = s;
        b.query_h           = t_word'($urandom());
        b.query_log_h       = t_word'($urandom());
        gen_abs[idx] = longint'(t_word'(xa[31:0]));
        gen_log[idx] = longint'(t_word'(xl[31:0]));
        return b;
    endfunction

    function automatic t_in query_beat(longint h, longint lh);
        t_in b;
        b.action            = ACT_QUERY;
        b.knot_index        = $urandom();
        b.knot_abscissa     = t_word'($urandom());
        b.knot_log_abscissa = t_word'($urandom());
        b.knot_value        = t_word'($urandom());
        b.knot_slope        = t_word'($urandom());
        b.query_h           = h[31:0];
        b.query_log_h       = lh[31:0];
        return b;
    endfunction

    // Queue a whole sorted table, so that no query can ever read an unloaded knot.
    // Zero steps give segments of zero width now and then.
    task automatic queue_table(bit wide);
        longint xa, xl;
        t_word  v, s;
        xa = -longint'($urandom_range(1 << 29));
        xl = -longint'($urandom_range(1 << 28));
        for (int k = 0; k < DEPTH; k++) begin
            v = wide ? any_word() : t_word'(int'($urandom_range(1 << 26)) - (1 << 25));
            s = wide ? any_word() : t_word'(int'($urandom_range(1 << 25)) - (1 << 24));
            pending_beats.push_back(load_beat(k, xa, xl, v, s));
            xa += ($urandom_range(29) == 0) ? 0 : $urandom_range(1 << 21);
            xl += ($urandom_range(29) == 0) ? 0 : $urandom_range(1 << 20);
        end
    endtask

    // Queries mostly fall near loaded knots so that every segment and both search
    // tables are reached; a few are arbitrary words.
    task automatic queue_query();
        int     k, n;
        longint h, lh;
        n = (gen_count < 3) ? 3 : ((gen_count > DEPTH) ? DEPTH : gen_count);
        k = $urandom_range(n - 1);
        case ($urandom_range(9))
            0: begin
                h  = longint'(t_word'($urandom()));
                lh = longint'(t_word'($urandom()));
            end
            1: begin
                h  = gen_abs[$urandom_range(1)] - $urandom_range(1 << 20);
                lh = gen_log[k];
            end
            2: begin
                h  = gen_abs[n-1] + $urandom_range(3);
                lh = gen_log[n-1] + longint'($urandom_range(1 << 21));
            end
            default: begin
                h  = gen_abs[k] + longint'($urandom_range(1 << 21)) - (1 << 19);
                lh = gen_log[k] + longint'($urandom_range(1 << 20)) - (1 << 18);
            end
        endcase
        if (h > 64'sd2147483647) h = 64'sd2147483647;
        if (lh > 64'sd2147483647) lh = 64'sd2147483647;
        pending_beats.push_back(query_beat(h, lh));
    endtask

    // Let the block go idle: all beats taken, all results seen, and loads retired.
    task automatic drain();
        while (pending_beats.size() > 0 || expected_results.size() > 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_ENTRY_COUNT) cfg_count = int'(data[CNT_W-1:0]);
        else if (idx == CFG_QUAD_THR) cfg_quad = longint'(t_word'(data));
        else if (idx == CFG_CUBIC_THR) cfg_cubic = longint'(t_word'(data));
        @(posedge i_clk);
    endtask

    task automatic set_regs(int count, longint quad, longint cubic);
        write_reg(CFG_ENTRY_COUNT, WORD_W'(count));
        write_reg(CFG_QUAD_THR, quad[31:0]);
        write_reg(CFG_CUBIC_THR, cubic[31:0]);
        gen_count = count & 9'h1FF;
    endtask

    // ---------------------------------------------------------------------------------
    // Test sequence.
    // ---------------------------------------------------------------------------------
    initial begin
        int counts[8] = '{3, 256, 0, 511, 17, 2, 300, 128};
        longint q, c;
        i_rst_n   <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_ENTRY_COUNT;
        cfg_data  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: load a table, then queries at the edges of each region
        // with thresholds placed inside the log table so that every order appears.
        queue_table(1'b0);
        drain();
        set_regs(256, gen_log[100], gen_log[160]);
        pending_beats.push_back(query_beat(gen_abs[0] - 5, gen_log[0]));
        pending_beats.push_back(query_beat(gen_abs[1], gen_log[1]));
        pending_beats.push_back(query_beat(gen_abs[0], gen_log[0]));
        pending_beats.push_back(query_beat(64'sd2147483647, 64'sd2147483647));
        pending_beats.push_back(query_beat(-64'sd2147483648, -64'sd2147483648));
        pending_beats.push_back(query_beat(gen_abs[1] + 1, gen_log[0] - 1000));
        pending_beats.push_back(query_beat(gen_abs[50], gen_log[50] + 7));
        pending_beats.push_back(query_beat(gen_abs[120], gen_log[120] + 7));
        pending_beats.push_back(query_beat(gen_abs[200], gen_log[200] + 7));
        pending_beats.push_back(query_beat(gen_abs[255] + 1, gen_log[255] + 99));
        pending_beats.push_back(query_beat(gen_abs[255], gen_log[255]));
        pending_beats.push_back(query_beat(gen_abs[40], gen_log[255] + (1 << 24)));
        // Overwrite a knot with extreme values so that saturation appears.
        pending_beats.push_back(load_beat(60, gen_abs[60], gen_log[60], WORD_MAX, WORD_MIN));
        pending_beats.push_back(query_beat(gen_abs[60], gen_log[60] + 3));
        pending_beats.push_back(query_beat(gen_abs[60], gen_log[59] + 3));
        drain();

        // Random phases, each with fresh registers; halfway through the table is
        // reloaded with wide knot values.
        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 4) queue_table(1'b1);
            drain();
            case (ph)
                1: begin q = -64'sd2147483648; c = -64'sd2147483648; end
                2: begin q = 64'sd2147483647;  c = 64'sd2147483647;  end
                3: begin q = gen_log[128];     c = -64'sd2147483648; end
                default: begin
                    q = gen_log[$urandom_range(255)];
                    c = gen_log[$urandom_range(255)];
                end
            endcase
            set_regs(counts[ph], q, c);
            for (int j = 0; j < 120; j++) begin
                if ($urandom_range(99) < 12) begin
                    // Stray knot rewrites, some of them breaking the ordering.
                    pending_beats.push_back(load_beat($urandom_range(255), any_word(),
                        any_word(), any_word(), any_word()));
                end else begin
                    queue_query();
                end
            end
            if (ph == 2) hold_req <= 1'b1;
            drain();
        end

        if (fail_count == 0) begin
            $display("[piecewise_hermite_table_interp] OK");
        end else begin
            $display("[piecewise_hermite_table_interp] ERROR");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("[piecewise_hermite_table_interp] ERROR");
        $finish;
    end

endmodule
